// ===== sv/gn3_pkg.sv =====
package gn3_pkg;

	// Permutation table geometry.
	localparam int TBL_ENTRIES = 256;
	localparam int TBL_AW      = 8;

	// Shuffle generator constants.
	localparam logic [31:0] LCG_MUL = 32'd214013;
	localparam logic [31:0] LCG_ADD = 32'd2531011;

	// Output range of the Q2.16 result.
	localparam int OUT_W   = 18;
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	// Codes of the kind field.
	localparam logic KIND_INIT = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// Shuffle sequencer states.
	typedef enum logic [2:0] {
		SH_IDLE,
		SH_FILL,
		SH_RAND,
		SH_MUL,
		SH_READ,
		SH_SWAPI,
		SH_SWAPJ
	} shuf_state_t;

	// Table access from the shuffle sequencer.
	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] waddr;
		logic [TBL_AW-1:0] wdata;
		logic              re;
		logic [TBL_AW-1:0] raddr0;
		logic [TBL_AW-1:0] raddr1;
	} tbl_port_t;

	// Control that travels with each pipeline stage.
	typedef struct packed {
		logic vld;
		logic init;
	} stage_ctl_t;

endpackage

// ===== sv/gradient_noise_3d.sv =====
// Three-dimensional gradient noise. An evaluate transaction (tuser 1) enters every
// cycle while the output is not stalled and no rebuild blocks the input; its Q2.16
// result leaves through the registered stages, one result per cycle while the
// output is not stalled. Seven copies of the 256-entry permutation table serve the
// fourteen lattice lookups. An init transaction (tuser 0) rebuilds the table from
// the seed register once it reaches the table stage, identity fill then shuffle,
// each swap split over the single write port; input tready drops from its acceptance
// until the rebuild ends. Before the first init the table reads as all zero.
module gradient_noise_3d #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] x_coord, [63:32] y_coord, [95:64] z_coord, [103:96] wrap_mask
	input  logic [103:0] s_axis_tdata,
	// [0] kind
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [17:0] noise_value, [23:18] zero
	output logic [23:0]  m_axis_tdata,
	// [0] init_done
	output logic         m_axis_tuser
);

	logic [31:0]                       seed_q;
	logic                              pend_q;
	logic                              tbl_ok_q;
	logic                              adv;
	logic                              accept;
	logic                              start;
	logic                              busy;
	logic                              init_at_s4;
	logic [gn3_pkg::TBL_AW-1:0]        rd0, rd1;
	logic signed [gn3_pkg::OUT_W-1:0]  noise;
	gn3_pkg::tbl_port_t                tbl;

	// The whole pipeline moves unless a result waits on the output.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv && !busy && !pend_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start         = pend_q && init_at_s4;
	assign m_axis_tdata  = {6'd0, noise};

	// Seed register, pending rebuild and table-built flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			pend_q   <= 1'b0;
			tbl_ok_q <= 1'b0;
		end else begin
			if (cfg_we) seed_q <= cfg_wdata;
			if (start) begin
				pend_q   <= 1'b0;
				tbl_ok_q <= 1'b1;
			end else if (accept && s_axis_tuser == gn3_pkg::KIND_INIT) begin
				pend_q <= 1'b1;
			end
		end
	end

	gn3_shuffle u_shuffle (
		.clk(clk), .arst_n(arst_n), .start(start), .seed(seed_q),
		.rd0(rd0), .rd1(rd1), .tbl(tbl), .busy(busy)
	);

	gn3_pipe #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_pipe (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(accept), .in_kind(s_axis_tuser),
		.in_x(s_axis_tdata[31:0]), .in_y(s_axis_tdata[63:32]),
		.in_z(s_axis_tdata[95:64]), .in_wrap(s_axis_tdata[103:96]),
		.tbl(tbl), .tbl_busy(busy), .tbl_ok(tbl_ok_q),
		.rd0(rd0), .rd1(rd1), .init_at_s4(init_at_s4),
		.out_vld(m_axis_tvalid), .out_init(m_axis_tuser), .out_noise(noise)
	);

endmodule

// ===== sv/gn3_perm_ram.sv =====
// One copy of the permutation table: one write port, two registered read ports.
module gn3_perm_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [gn3_pkg::TBL_AW-1:0] waddr,
	input  logic [gn3_pkg::TBL_AW-1:0] wdata,
	input  logic                       re,
	input  logic [gn3_pkg::TBL_AW-1:0] raddr0,
	input  logic [gn3_pkg::TBL_AW-1:0] raddr1,
	output logic [gn3_pkg::TBL_AW-1:0] rdata0,
	output logic [gn3_pkg::TBL_AW-1:0] rdata1
);

	logic [gn3_pkg::TBL_AW-1:0] mem_q [gn3_pkg::TBL_ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read ports; the data holds while the enable is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

// ===== sv/gn3_shuffle.sv =====
// Table rebuild sequencer: identity fill, then a Fisher-Yates pass driven by the LCG.
module gn3_shuffle (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                seed,
	input  logic [gn3_pkg::TBL_AW-1:0] rd0,
	input  logic [gn3_pkg::TBL_AW-1:0] rd1,
	output gn3_pkg::tbl_port_t         tbl,
	output logic                       busy
);

	gn3_pkg::shuf_state_t state_q, state_d;
	logic [gn3_pkg::TBL_AW-1:0] cnt_q;
	logic [gn3_pkg::TBL_AW-1:0] j_q;
	logic [31:0]                lcg_q;
	logic [14:0]                r_q;
	logic [31:0]                lcg_next;
	logic [23:0]                jprod;

	assign lcg_next = lcg_q * gn3_pkg::LCG_MUL + gn3_pkg::LCG_ADD;
	assign jprod    = r_q * ({1'b0, cnt_q} + 9'd1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gn3_pkg::SH_IDLE:  if (start) state_d = gn3_pkg::SH_FILL;
			gn3_pkg::SH_FILL:  if (cnt_q == '1) state_d = gn3_pkg::SH_RAND;
			gn3_pkg::SH_RAND:  state_d = gn3_pkg::SH_MUL;
			gn3_pkg::SH_MUL:   state_d = gn3_pkg::SH_READ;
			gn3_pkg::SH_READ:  state_d = gn3_pkg::SH_SWAPI;
			gn3_pkg::SH_SWAPI: state_d = gn3_pkg::SH_SWAPJ;
			gn3_pkg::SH_SWAPJ: begin
				state_d = (cnt_q == 8'd1) ? gn3_pkg::SH_IDLE : gn3_pkg::SH_RAND;
			end
			default:           state_d = gn3_pkg::SH_IDLE;
		endcase
	end

	// Table port drive.
	always_comb begin
		tbl.we     = 1'b0;
		tbl.waddr  = cnt_q;
		tbl.wdata  = cnt_q;
		tbl.re     = 1'b0;
		tbl.raddr0 = cnt_q;
		tbl.raddr1 = j_q;
		busy       = (state_q != gn3_pkg::SH_IDLE);
		case (state_q)
			gn3_pkg::SH_FILL:  tbl.we = 1'b1;
			gn3_pkg::SH_READ:  tbl.re = 1'b1;
			gn3_pkg::SH_SWAPI: begin
				tbl.we    = 1'b1;
				tbl.wdata = rd1;
			end
			gn3_pkg::SH_SWAPJ: begin
				tbl.we    = 1'b1;
				tbl.waddr = j_q;
				tbl.wdata = rd0;
			end
			default: begin
			end
		endcase
	end

	// State, counter and generator registers; the fill leaves the counter on the
	// last entry, where the shuffle starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gn3_pkg::SH_IDLE;
			cnt_q   <= '0;
			lcg_q   <= '0;
			r_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				gn3_pkg::SH_IDLE: begin
					cnt_q <= '0;
					if (start) lcg_q <= seed;
				end
				gn3_pkg::SH_FILL:  if (cnt_q != '1) cnt_q <= cnt_q + 8'd1;
				gn3_pkg::SH_RAND: begin
					lcg_q <= lcg_next;
					r_q   <= lcg_next[30:16];
				end
				gn3_pkg::SH_MUL:   j_q <= jprod[22:15];
				gn3_pkg::SH_SWAPJ: cnt_q <= cnt_q - 8'd1;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/gn3_pipe.sv =====
// Evaluation pipeline: lattice split, three table lookup levels, gradients,
// fade and three levels of interpolation, each multiply followed by a register.
module gn3_pipe #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_vld,
	input  logic                                 in_kind,
	input  logic [31:0]                          in_x,
	input  logic [31:0]                          in_y,
	input  logic [31:0]                          in_z,
	input  logic [7:0]                           in_wrap,
	input  gn3_pkg::tbl_port_t                   tbl,
	input  logic                                 tbl_busy,
	input  logic                                 tbl_ok,
	output logic [gn3_pkg::TBL_AW-1:0]           rd0,
	output logic [gn3_pkg::TBL_AW-1:0]           rd1,
	output logic                                 init_at_s4,
	output logic                                 out_vld,
	output logic                                 out_init,
	output logic signed [gn3_pkg::OUT_W-1:0]     out_noise
);

	localparam int F  = COORD_FRAC_BITS;
	localparam int GW = F + 2;
	localparam int DW = GW + 1;
	localparam int PW = DW + F + 2;
	localparam int CW = GW + 16;
	localparam int AW = gn3_pkg::TBL_AW;
	localparam logic signed [GW-1:0] ONE   = GW'(1) << F;
	localparam logic [F+1:0]         THREE = (F + 2)'(3) << F;

	typedef logic [F:0] fade_t [3];

	// Gradient selection; codes 12 and 13 repeat the first two.
	function automatic logic signed [GW-1:0] grad(
		input logic [3:0]           code,
		input logic signed [GW-1:0] x,
		input logic signed [GW-1:0] y,
		input logic signed [GW-1:0] z
	);
		case (code)
			4'd0, 4'd12:  grad = x + y;
			4'd1, 4'd13:  grad = -x + y;
			4'd2:         grad = x - y;
			4'd3:         grad = -x - y;
			4'd4:         grad = x + z;
			4'd5:         grad = -x + z;
			4'd6:         grad = x - z;
			4'd7:         grad = -x - z;
			4'd8:         grad = y + z;
			4'd9:         grad = -y + z;
			4'd10, 4'd14: grad = y - z;
			default:      grad = -y - z;
		endcase
	endfunction

	gn3_pkg::stage_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	gn3_pkg::stage_ctl_t ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10;

	logic [AW-1:0] lo_s1 [3];
	logic [AW-1:0] hi_s1 [3];
	logic [F-1:0]  t_s1 [3];
	logic [AW-1:0] lo_s2 [3];
	logic [AW-1:0] hi_s2 [3];
	logic [F-1:0]  t_s2 [3];
	logic [F-1:0]  t2_s2 [3];
	logic [F+1:0]  k_s2 [3];
	logic [AW-1:0] lo2_s3, hi2_s3;
	logic [F-1:0]  t_s3 [3];
	logic [F-1:0]  t_s4 [3];
	fade_t         fd_s3, fd_s4, fd_s5, fd_s6, fd_s7, fd_s8, fd_s9;

	logic [AW-1:0] ra_lo, ra_hi;
	logic [AW-1:0] rb0, rb1, rc0, rc1;
	logic [AW-1:0] g_raw [8];
	logic [AW-1:0] hlo, hhi, a0, a1, a2, a3;
	logic [AW-1:0] ca_addr0, ca_addr1;
	logic          ca_en;

	logic signed [GW-1:0] f_s5 [8];
	logic signed [GW-1:0] za_s6 [4];
	logic signed [PW-1:0] zp_s6 [4];
	logic signed [GW-1:0] zl_s7 [4];
	logic signed [GW-1:0] ya_s8 [2];
	logic signed [PW-1:0] yp_s8 [2];
	logic signed [GW-1:0] yl_s9 [2];
	logic signed [GW-1:0] xa_s10;
	logic signed [PW-1:0] xp_s10;

	logic [31:0]          coord [3];
	logic [AW-1:0]        lo_in [3];
	logic signed [GW-1:0] px, py, pz, pxm, pym, pzm;
	logic signed [GW-1:0] xl;
	logic signed [CW-1:0] wide;

	assign coord[0] = in_x;
	assign coord[1] = in_y;
	assign coord[2] = in_z;

	// Stage 1: floor to the lattice, wrap, keep the fraction.
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			lo_in[d] = coord[d][F +: AW] & in_wrap;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < 3; d++) begin
				lo_s1[d] <= lo_in[d];
				hi_s1[d] <= (lo_in[d] + 8'd1) & in_wrap;
				t_s1[d]  <= coord[d][F-1:0];
			end
		end
	end

	// First lookup level; the rebuild sequencer shares this copy.
	assign ca_en    = tbl_busy ? tbl.re : adv;
	assign ca_addr0 = tbl_busy ? tbl.raddr0 : lo_s1[0];
	assign ca_addr1 = tbl_busy ? tbl.raddr1 : hi_s1[0];
	assign rd0      = ra_lo;
	assign rd1      = ra_hi;

	gn3_perm_ram u_ram_a (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(ca_en), .raddr0(ca_addr0), .raddr1(ca_addr1),
		.rdata0(ra_lo), .rdata1(ra_hi)
	);

	// Stage 2: first fade product.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < 3; d++) begin
				lo_s2[d] <= lo_s1[d];
				hi_s2[d] <= hi_s1[d];
				t_s2[d]  <= t_s1[d];
				t2_s2[d] <= F'((2 * F)'(t_s1[d]) * (2 * F)'(t_s1[d]) >> F);
				k_s2[d]  <= THREE - {1'b0, t_s1[d], 1'b0};
			end
		end
	end

	// A table that was never built reads as zero.
	assign hlo = tbl_ok ? ra_lo : '0;
	assign hhi = tbl_ok ? ra_hi : '0;

	gn3_perm_ram u_ram_b (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(adv), .raddr0(hlo + lo_s2[1]), .raddr1(hlo + hi_s2[1]),
		.rdata0(rb0), .rdata1(rb1)
	);

	gn3_perm_ram u_ram_c (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(adv), .raddr0(hhi + lo_s2[1]), .raddr1(hhi + hi_s2[1]),
		.rdata0(rc0), .rdata1(rc1)
	);

	// Stage 3: second fade product.
	always_ff @(posedge clk) begin
		if (adv) begin
			lo2_s3 <= lo_s2[2];
			hi2_s3 <= hi_s2[2];
			for (int d = 0; d < 3; d++) begin
				t_s3[d]  <= t_s2[d];
				fd_s3[d] <= (F + 1)'(((2 * F + 2)'(t2_s2[d]) * (2 * F + 2)'(k_s2[d])) >> F);
			end
		end
	end

	assign a0 = tbl_ok ? rb0 : '0;
	assign a2 = tbl_ok ? rb1 : '0;
	assign a1 = tbl_ok ? rc0 : '0;
	assign a3 = tbl_ok ? rc1 : '0;

	gn3_perm_ram u_ram_d (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(adv), .raddr0(a0 + lo2_s3), .raddr1(a0 + hi2_s3),
		.rdata0(g_raw[0]), .rdata1(g_raw[4])
	);

	gn3_perm_ram u_ram_e (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(adv), .raddr0(a1 + lo2_s3), .raddr1(a1 + hi2_s3),
		.rdata0(g_raw[1]), .rdata1(g_raw[5])
	);

	gn3_perm_ram u_ram_f (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(adv), .raddr0(a2 + lo2_s3), .raddr1(a2 + hi2_s3),
		.rdata0(g_raw[2]), .rdata1(g_raw[6])
	);

	gn3_perm_ram u_ram_g (
		.clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
		.re(adv), .raddr0(a3 + lo2_s3), .raddr1(a3 + hi2_s3),
		.rdata0(g_raw[3]), .rdata1(g_raw[7])
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s4  <= t_s3;
			fd_s4 <= fd_s3;
		end
	end

	// Stage 4: corner offsets and gradient dot products.
	assign px  = $signed(GW'(t_s4[0]));
	assign py  = $signed(GW'(t_s4[1]));
	assign pz  = $signed(GW'(t_s4[2]));
	assign pxm = px - ONE;
	assign pym = py - ONE;
	assign pzm = pz - ONE;

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s5   <= fd_s4;
			f_s5[0] <= grad(tbl_ok ? g_raw[0][3:0] : 4'd0, px,  py,  pz);
			f_s5[1] <= grad(tbl_ok ? g_raw[1][3:0] : 4'd0, pxm, py,  pz);
			f_s5[2] <= grad(tbl_ok ? g_raw[2][3:0] : 4'd0, px,  pym, pz);
			f_s5[3] <= grad(tbl_ok ? g_raw[3][3:0] : 4'd0, pxm, pym, pz);
			f_s5[4] <= grad(tbl_ok ? g_raw[4][3:0] : 4'd0, px,  py,  pzm);
			f_s5[5] <= grad(tbl_ok ? g_raw[5][3:0] : 4'd0, pxm, py,  pzm);
			f_s5[6] <= grad(tbl_ok ? g_raw[6][3:0] : 4'd0, px,  pym, pzm);
			f_s5[7] <= grad(tbl_ok ? g_raw[7][3:0] : 4'd0, pxm, pym, pzm);
		end
	end

	// Stages 5 to 10: interpolation along z, then y, then x.
	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s6 <= fd_s5;
			fd_s7 <= fd_s6;
			fd_s8 <= fd_s7;
			fd_s9 <= fd_s8;
			for (int k = 0; k < 4; k++) begin
				za_s6[k] <= f_s5[k];
				zp_s6[k] <= PW'((DW'(f_s5[k + 4]) - DW'(f_s5[k]))
					* $signed({1'b0, fd_s5[2]}));
				zl_s7[k] <= GW'(za_s6[k] + (zp_s6[k] >>> F));
			end
			for (int k = 0; k < 2; k++) begin
				ya_s8[k] <= zl_s7[k];
				yp_s8[k] <= PW'((DW'(zl_s7[k + 2]) - DW'(zl_s7[k]))
					* $signed({1'b0, fd_s7[1]}));
				yl_s9[k] <= GW'(ya_s8[k] + (yp_s8[k] >>> F));
			end
			xa_s10 <= yl_s9[0];
			xp_s10 <= PW'((DW'(yl_s9[1]) - DW'(yl_s9[0])) * $signed({1'b0, fd_s9[0]}));
		end
	end

	// Last interpolation, rescale to Q2.16 with floor, saturate.
	assign xl   = GW'(xa_s10 + (xp_s10 >>> F));
	assign wide = (CW'(xl) <<< 16) >>> F;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_s10.init) begin
				out_noise <= '0;
			end else if (wide > CW'(gn3_pkg::OUT_MAX)) begin
				out_noise <= gn3_pkg::OUT_W'(gn3_pkg::OUT_MAX);
			end else if (wide < CW'(gn3_pkg::OUT_MIN)) begin
				out_noise <= gn3_pkg::OUT_W'(gn3_pkg::OUT_MIN);
			end else begin
				out_noise <= gn3_pkg::OUT_W'(wide);
			end
		end
	end

	// Valid and kind travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			ctl_s4   <= '0;
			ctl_s5   <= '0;
			ctl_s6   <= '0;
			ctl_s7   <= '0;
			ctl_s8   <= '0;
			ctl_s9   <= '0;
			ctl_s10  <= '0;
			out_vld  <= 1'b0;
			out_init <= 1'b0;
		end else if (adv) begin
			ctl_s1.vld  <= in_vld;
			ctl_s1.init <= in_vld && (in_kind == gn3_pkg::KIND_INIT);
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			ctl_s5      <= ctl_s4;
			ctl_s6      <= ctl_s5;
			ctl_s7      <= ctl_s6;
			ctl_s8      <= ctl_s7;
			ctl_s9      <= ctl_s8;
			ctl_s10     <= ctl_s9;
			out_vld     <= ctl_s10.vld;
			out_init    <= ctl_s10.init;
		end
	end

	assign init_at_s4 = ctl_s4.vld && ctl_s4.init;

endmodule

// ===== sv/gn3_checker.sv =====
// Port-level checks of the noise unit.
module gn3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed under stall");

	// An init acknowledgment carries a zero value.
	a_init_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
		else $error("init result not zero");

	// Padding bits above the value stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
		else $error("result padding not zero");

	// An accepted init blocks the input; this checks that ready is low right after the acceptance.
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == gn3_pkg::KIND_INIT
		|=> !s_axis_tready)
		else $error("input ready right after init");

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ===== verif/gradient_noise_3d_test.sv =====
module gradient_noise_3d_test;

	// One expected output transaction.
	typedef struct {
		logic signed [17:0] noise;
		logic               done;
	} noise_result_t;

	// Holds the block's table state and the queue of expected noise results.
	class noise_scoreboard;
		logic [7:0]    perm [256];
		logic [31:0]   seed;
		noise_result_t pending [$];
		int            errors;

		function void clear_state();
			foreach (perm[i]) perm[i] = 8'd0;
			seed = 32'd0;
			errors = 0;
		endfunction

		function void rebuild();
			logic [31:0] lcg;
			logic [63:0] prod;
			logic [7:0]  tmp;
			int          j;
			lcg = seed;
			for (int i = 0; i < 256; i++) perm[i] = i[7:0];
			for (int i = 255; i > 0; i--) begin
				lcg = lcg * gn3_pkg::LCG_MUL + gn3_pkg::LCG_ADD;
				prod = 64'(lcg[30:16]) * 64'(i + 1);
				j = int'(prod >> 15) & 255;
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
		endfunction

		function logic [7:0] lookup(int idx);
			return perm[idx & 255];
		endfunction

		function longint gradient(int code, longint x, longint y, longint z);
			case (code & 15)
				0, 12: return x + y;
				1, 13: return -x + y;
				2: return x - y;
				3: return -x - y;
				4: return x + z;
				5: return -x + z;
				6: return x - z;
				7: return -x - z;
				8: return y + z;
				9: return -y + z;
				10, 14: return y - z;
				default: return -y - z;
			endcase
		endfunction

		function longint smooth(longint t);
			longint t2;
			t2 = (t * t) >>> 16;
			return (t2 * ((longint'(3) << 16) - 2 * t)) >>> 16;
		endfunction

		// Arithmetic shift of a signed longint floors.
		function longint blend(longint a, longint b, longint s);
			return a + (((b - a) * s) >>> 16);
		endfunction

		function logic signed [17:0] evaluate(logic [103:0] d);
			longint p [3];
			longint f [8];
			int     lo [3], hi [3];
			int     m, h, a0, a1, a2, a3;
			longint v, c, one;
			one = longint'(1) << 16;
			m = d[103:96];
			for (int k = 0; k < 3; k++) begin
				c = longint'($signed(d[32*k +: 32]));
				p[k] = c & 64'hFFFF;
				lo[k] = int'(c >>> 16) & m;
				hi[k] = (lo[k] + 1) & m;
			end
			h = lookup(lo[0]);
			a0 = lookup(h + lo[1]);
			a2 = lookup(h + hi[1]);
			h = lookup(hi[0]);
			a1 = lookup(h + lo[1]);
			a3 = lookup(h + hi[1]);
			f[0] = gradient(lookup(a0 + lo[2]), p[0], p[1], p[2]);
			f[1] = gradient(lookup(a1 + lo[2]), p[0] - one, p[1], p[2]);
			f[2] = gradient(lookup(a2 + lo[2]), p[0], p[1] - one, p[2]);
			f[3] = gradient(lookup(a3 + lo[2]), p[0] - one, p[1] - one, p[2]);
			f[4] = gradient(lookup(a0 + hi[2]), p[0], p[1], p[2] - one);
			f[5] = gradient(lookup(a1 + hi[2]), p[0] - one, p[1], p[2] - one);
			f[6] = gradient(lookup(a2 + hi[2]), p[0], p[1] - one, p[2] - one);
			f[7] = gradient(lookup(a3 + hi[2]), p[0] - one, p[1] - one, p[2] - one);
			for (int k = 0; k < 3; k++) p[k] = smooth(p[k]);
			for (int k = 0; k < 4; k++) f[k] = blend(f[k], f[k + 4], p[2]);
			f[0] = blend(f[0], f[2], p[1]);
			f[1] = blend(f[1], f[3], p[1]);
			v = blend(f[0], f[1], p[0]);
			if (v > gn3_pkg::OUT_MAX) v = gn3_pkg::OUT_MAX;
			if (v < gn3_pkg::OUT_MIN) v = gn3_pkg::OUT_MIN;
			return v[17:0];
		endfunction

		function void note_input(logic kind, logic [103:0] d);
			noise_result_t r;
			if (kind == gn3_pkg::KIND_INIT) begin
				rebuild();
				r.noise = '0;
				r.done = 1'b1;
			end else begin
				r.noise = evaluate(d);
				r.done = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_output(logic [23:0] d, logic u);
			noise_result_t r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result noise=%0d done=%0b",
					$signed(d[17:0]), u);
				return;
			end
			r = pending.pop_front();
			if (d[17:0] !== r.noise || d[23:18] !== 6'd0 || u !== r.done) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected noise=%0d done=%0b, got noise=%0d pad=%0h done=%0b",
						r.noise, r.done, $signed(d[17:0]), d[23:18], u);
			end
		endfunction
	endclass

	logic         clk, arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [103:0] s_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
	logic [23:0]  m_axis_tdata;

	noise_scoreboard board;
	int  cycle_count;
	bit  hold_off_request;

	gradient_noise_3d DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bookkeeping of both handshakes, sampled at the rising edge.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_input(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_output(m_axis_tdata, m_axis_tuser);
	end

	// Receiver stall pattern, with an occasional long hold-off on request.
	initial begin
		int stall, run;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off_request = 1'b0;
			end
			run = $urandom_range(1, 40);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			m_axis_tready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Timeout watchdog.
	initial begin
		wait (cycle_count > 900000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(logic kind, logic [103:0] d);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait until the scoreboard holds nothing, then allow the pipeline to settle.
	task automatic drain();
		pause(1);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.seed = v;
	endtask

	function automatic logic [103:0] point(logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [7:0] m);
		return {m, z, y, x};
	endfunction

	// Coordinates mostly of modest size, sometimes full range or edge values.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			2: return {16'($urandom()), 16'hFFFF};
			3: return {16'($urandom()), 16'h0000};
			default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
		endcase
	endfunction

	function automatic logic [7:0] rand_mask();
		case ($urandom_range(0, 3))
			0: return 8'hFF;
			1: return 8'($urandom());
			2: return 8'((1 << $urandom_range(0, 8)) - 1);
			default: return 8'hFF;
		endcase
	endfunction

	task automatic random_phase(int count);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && sent < count; k++) begin
				if ($urandom_range(0, 199) == 0)
					send_item(gn3_pkg::KIND_INIT,
						{$urandom(), $urandom(), $urandom(), $urandom()});
				else
					send_item(gn3_pkg::KIND_EVAL, point(rand_coord(), rand_coord(),
						rand_coord(), rand_mask()));
				sent++;
			end
			if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
		end
	endtask

	initial begin
		board = new();
		board.clear_state();
		cycle_count = 0;
		hold_off_request = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = gn3_pkg::KIND_EVAL;
		s_axis_tdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Evaluations before any init read the all-zero table.
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h0001_8000, 32'h0000_4000, 32'hFFFF_C000, 8'hFF));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'hFF));
		drain();

		// Extreme seed values, with directed points under the first and random points under the second.
		write_seed(32'h0000_0000);
		send_item(gn3_pkg::KIND_INIT, '0);
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'hFF));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'hFFFF_FFFF, 32'hFFFF_0001, 32'hFFFE_8000, 8'h0F));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 8'hFF));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h00FF_8000, 32'h0100_8000, 32'hFF00_8000, 8'hFF));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 8'hAA));
		send_item(gn3_pkg::KIND_EVAL,
			point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_AAAA, 8'h55));
		drain();
		write_seed(32'hFFFF_FFFF);
		send_item(gn3_pkg::KIND_INIT, {$urandom(), $urandom(), $urandom(), $urandom()});
		for (int k = 0; k < 8; k++)
			send_item(gn3_pkg::KIND_EVAL,
				point(rand_coord(), rand_coord(), rand_coord(), 8'hFF));
		drain();

		// Long receiver hold-off while the sender keeps offering evaluations.
		hold_off_request = 1'b1;
		for (int k = 0; k < 60; k++)
			send_item(gn3_pkg::KIND_EVAL,
				point(rand_coord(), rand_coord(), rand_coord(), rand_mask()));
		drain();

		// Random phases under several seeds.
		for (int ph = 0; ph < 5; ph++) begin
			write_seed((ph == 0) ? 32'h8000_0000 : $urandom());
			send_item(gn3_pkg::KIND_INIT, '0);
			random_phase(360);
			drain();
		end

		s_axis_tvalid <= 1'b0;
		drain();
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/gn3_pkg.sv
sv/gn3_perm_ram.sv
sv/gn3_shuffle.sv
sv/gn3_pipe.sv
sv/gradient_noise_3d.sv
sv/gn3_checker.sv
verif/gradient_noise_3d_test.sv
